>>> rtl/core/assert_macros.svh
// assertion macros for the registry rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HOR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define HOR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/hor_pkg.sv
// shared types and constants of the hashed object registry
`timescale 1ns / 1ps
package hor_pkg;
	localparam int ADDR_W   = 48;
	localparam int KIND_W   = 4;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 10;
	localparam int HELD_W   = 11;

	// key mixing constants
	localparam int          MIX_PRE_SHIFT  = 4;
	localparam int          MIX_XOR_SHIFT1 = 17;
	localparam int          MIX_XOR_SHIFT2 = 11;
	localparam logic [31:0] MIX_MULT       = 32'hED5AD4BB;
	// product bits that reach the low 32 bits after the final xor
	localparam int          MIX_KEEP_W     = 32 + MIX_XOR_SHIFT2;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_IGNORED   = 3'd2,
		ST_FULL      = 3'd3,
		ST_REBUILT   = 3'd4,
		ST_DUPLICATE = 3'd5
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] count;
		logic [WORD_W-1:0] stride;
		logic [WORD_W-1:0] flags;
	} payload_t;
endpackage

>>> rtl/core/hor_hash.sv
// multi-cycle key mixer producing the first probe position
`timescale 1ns / 1ps
module hor_hash #(
	parameter int INDEX_CAPACITY = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hor_pkg::ADDR_W-1:0]        key,
	output logic                              done,
	output logic [$clog2(INDEX_CAPACITY)-1:0] pos
);
	import hor_pkg::*;

	localparam int  PW      = $clog2(INDEX_CAPACITY);
	localparam int  HI_W    = MIX_KEEP_W - 32;
	localparam bit  IS_POW2 = (INDEX_CAPACITY & (INDEX_CAPACITY - 1)) == 0;

	logic [ADDR_W-1:0]     h0;
	logic [ADDR_W-1:0]     h1;
	logic [MIX_KEEP_W-1:0] mix_s1;
	logic [63:0]           plo_s2;
	logic [HI_W-1:0]       phi_s2;
	logic [MIX_KEEP_W-1:0] prod;
	logic [MIX_KEEP_W-1:0] mixed;
	logic [31:0]           hash_s3;
	logic                  v1_q, v2_q, v3_q;

	assign h0    = key >> MIX_PRE_SHIFT;
	assign h1    = h0 ^ (h0 >> MIX_XOR_SHIFT1);
	assign prod  = plo_s2[MIX_KEEP_W-1:0] + {phi_s2, 32'd0};
	assign mixed = prod ^ (prod >> MIX_XOR_SHIFT2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= start;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	// split product keeps each multiplier within 32 by 32
	always_ff @(posedge clk) begin
		mix_s1  <= h1[MIX_KEEP_W-1:0];
		plo_s2  <= {32'd0, mix_s1[31:0]} * {32'd0, MIX_MULT};
		phi_s2  <= HI_W'(mix_s1[MIX_KEEP_W-1:32] * MIX_MULT[HI_W-1:0]);
		hash_s3 <= mixed[31:0];
	end

	generate
		if (IS_POW2) begin : g_mask
			assign done = v3_q;
			assign pos  = hash_s3[PW-1:0];
		end else begin : g_reduce
			// reciprocal multiply gives the quotient or one less, then one correction
			localparam int          RS    = 31 + PW;
			localparam logic [63:0] RECIP = (64'd1 << RS) / 64'(INDEX_CAPACITY);
			localparam logic [31:0] CAP   = 32'(INDEX_CAPACITY);
			logic [63:0] qprod_s4;
			logic [31:0] hash_s4;
			logic [31:0] rem_s5;
			logic [31:0] quot;
			logic        v4_q, v5_q;

			assign quot = 32'(qprod_s4 >> RS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v4_q <= 1'b0;
					v5_q <= 1'b0;
				end else begin
					v4_q <= v3_q;
					v5_q <= v4_q;
				end
			end

			always_ff @(posedge clk) begin
				qprod_s4 <= {32'd0, hash_s3} * {32'd0, RECIP[31:0]};
				hash_s4  <= hash_s3;
				rem_s5   <= hash_s4 - quot * CAP;
			end

			assign done = v5_q;
			assign pos  = (rem_s5 >= CAP) ? PW'(rem_s5 - CAP) : rem_s5[PW-1:0];
		end
	endgenerate
endmodule

>>> rtl/core/hor_index_mem.sv
// index table memory, one write and one registered read port
`timescale 1ns / 1ps
module hor_index_mem #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/hor_record_mem.sv
// record store: key memory with registered read, payload memory
`timescale 1ns / 1ps
module hor_record_mem #(
	parameter int DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [hor_pkg::ADDR_W-1:0] wkey,
	input  hor_pkg::payload_t          wpayload,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [hor_pkg::ADDR_W-1:0] rkey
);
	import hor_pkg::*;

	logic [ADDR_W-1:0] key_mem [DEPTH];
	payload_t          payload_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr]     <= wkey;
			payload_mem[waddr] <= wpayload;
		end
		rkey <= key_mem[raddr];
	end
endmodule

>>> rtl/core/hashed_object_registry_top.sv
// top level of the hashed object registry: control sequencer and memories
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Registry of object records keyed by a 48-bit address. One transaction in
// gives exactly one transaction out. The block handles one transaction at a
// time; in_stall is high while it works. After reset, and at the start of
// every rebuild, the index memory is swept to empty at one entry per cycle,
// during which no transaction is taken. A register request with a zero
// address or zero count skips the mixer and the probe. Otherwise the key goes
// through the mixer, whose reduction adds stages when the index size is not a
// power of two, and then linear probing visits entries in turn, each visit
// reading the index memory and, for an occupied entry, then the record key
// memory. A rebuild costs the sweep plus, per stored record, one key read,
// the mixer and its probe. A finished result waits in the output register
// while the next transaction is taken.
module hashed_object_registry_top #(
	parameter int RECORD_CAPACITY = 1024,
	parameter int INDEX_CAPACITY  = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [hor_pkg::ADDR_W-1:0]   address,
	input  logic [hor_pkg::KIND_W-1:0]   object_kind,
	input  logic [hor_pkg::WORD_W-1:0]   element_count,
	input  logic [hor_pkg::WORD_W-1:0]   element_stride,
	input  logic [hor_pkg::WORD_W-1:0]   record_flags,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hor_pkg::STATUS_W-1:0] status,
	output logic [hor_pkg::SLOT_W-1:0]   record_slot,
	output logic [hor_pkg::HELD_W-1:0]   records_held
);
	import hor_pkg::*;

	localparam int RW = $clog2(RECORD_CAPACITY);     // record slot
	localparam int TW = $clog2(RECORD_CAPACITY + 1); // record total, index entry
	localparam int PW = $clog2(INDEX_CAPACITY);      // index position
	localparam int NW = $clog2(INDEX_CAPACITY + 1);  // probe count

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b0000000001,
		S_IDLE     = 10'b0000000010,
		S_HASH     = 10'b0000000100,
		S_PROBE_RD = 10'b0000001000,
		S_IDX      = 10'b0000010000,
		S_REC      = 10'b0000100000,
		S_FINISH   = 10'b0001000000,
		S_REB_RD   = 10'b0010000000,
		S_REB_KEY  = 10'b0100000000,
		S_OUT      = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic              rebuild_q;   // current work is a rebuild
	logic              conflict_q;  // rebuild has met a conflict
	logic              empty_q;     // probe ended on an empty entry
	logic              match_q;     // probe ended on the key
	logic [PW-1:0]     clr_q;
	logic [PW-1:0]     pos_q;
	logic [NW-1:0]     n_q;
	logic [TW-1:0]     entry_q;
	logic [TW-1:0]     total_q;
	logic [TW-1:0]     i_q;
	logic [ADDR_W-1:0] key_q;
	payload_t          payload_q;
	status_t           res_status_q;
	logic [RW-1:0]     res_slot_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [HELD_W-1:0] held_q;

	// hash unit
	logic              hash_start;
	logic [ADDR_W-1:0] hash_key;
	logic              hash_done;
	logic [PW-1:0]     hash_pos;

	// memories
	logic              idx_we;
	logic [PW-1:0]     idx_waddr;
	logic [TW-1:0]     idx_wdata;
	logic [TW-1:0]     idx_rdata;
	logic              rec_we;
	logic [RW-1:0]     rec_waddr;
	logic [RW-1:0]     rec_raddr;
	logic [ADDR_W-1:0] rec_rkey;

	logic              in_take;
	logic              out_free;
	logic [RW-1:0]     entry_slot;
	logic [RW-1:0]     hit_slot;

	assign in_take    = in_valid && !in_stall;
	assign in_stall   = state_q != S_IDLE;
	assign out_free   = !out_valid_q || !out_stall;
	assign entry_slot = RW'(idx_rdata - TW'(1));
	assign hit_slot   = RW'(entry_q - TW'(1));

	assign hash_start = (state_q == S_IDLE && in_take && !operation &&
		address != '0 && element_count != '0) || state_q == S_REB_KEY;
	assign hash_key   = (state_q == S_REB_KEY) ? rec_rkey : address;

	hor_hash #(
		.INDEX_CAPACITY(INDEX_CAPACITY)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (hash_key),
		.done  (hash_done),
		.pos   (hash_pos)
	);

	hor_index_mem #(
		.DEPTH(INDEX_CAPACITY),
		.WIDTH(TW)
	) u_index (
		.clk  (clk),
		.we   (idx_we),
		.waddr(idx_waddr),
		.wdata(idx_wdata),
		.raddr(pos_q),
		.rdata(idx_rdata)
	);

	hor_record_mem #(
		.DEPTH(RECORD_CAPACITY)
	) u_records (
		.clk     (clk),
		.we      (rec_we),
		.waddr   (rec_waddr),
		.wkey    (key_q),
		.wpayload(payload_q),
		.raddr   (rec_raddr),
		.rkey    (rec_rkey)
	);

	// memory write and read-address steering
	always_comb begin
		idx_we    = 1'b0;
		idx_waddr = pos_q;
		idx_wdata = '0;
		rec_we    = 1'b0;
		rec_waddr = hit_slot;
		rec_raddr = i_q[RW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				// sweep the index to empty
				idx_we    = 1'b1;
				idx_waddr = clr_q;
			end
			S_IDX: begin
				rec_raddr = entry_slot;
			end
			S_FINISH: begin
				if (rebuild_q) begin
					idx_we    = empty_q;
					idx_wdata = i_q + TW'(1);
				end else if (match_q) begin
					rec_we = 1'b1;
				end else if (empty_q && total_q < TW'(RECORD_CAPACITY)) begin
					rec_we    = 1'b1;
					rec_waddr = total_q[RW-1:0];
					idx_we    = 1'b1;
					idx_wdata = total_q + TW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			rebuild_q  <= 1'b0;
			conflict_q <= 1'b0;
			clr_q      <= '0;
			total_q    <= '0;
			i_q        <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == PW'(INDEX_CAPACITY - 1)) begin
						clr_q      <= '0;
						i_q        <= '0;
						conflict_q <= 1'b0;
						state_q    <= rebuild_q ? S_REB_RD : S_IDLE;
					end else begin
						clr_q <= clr_q + PW'(1);
					end
				end
				S_IDLE: begin
					if (in_take) begin
						if (operation) begin
							rebuild_q <= 1'b1;
							state_q   <= S_CLEAR;
						end else if (address == '0 || element_count == '0) begin
							rebuild_q <= 1'b0;
							state_q   <= S_OUT;
						end else begin
							rebuild_q <= 1'b0;
							state_q   <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_PROBE_RD;
					end
				end
				S_PROBE_RD: begin
					state_q <= S_IDX;
				end
				S_IDX: begin
					state_q <= (idx_rdata == '0) ? S_FINISH : S_REC;
				end
				S_REC: begin
					if (rec_rkey == key_q || n_q == NW'(INDEX_CAPACITY - 1)) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_PROBE_RD;
					end
				end
				S_FINISH: begin
					if (rebuild_q) begin
						if (!empty_q && !conflict_q) begin
							conflict_q <= 1'b1;
						end
						i_q     <= i_q + TW'(1);
						state_q <= S_REB_RD;
					end else begin
						if (!match_q && empty_q && total_q < TW'(RECORD_CAPACITY)) begin
							total_q <= total_q + TW'(1);
						end
						state_q <= S_OUT;
					end
				end
				S_REB_RD: begin
					state_q <= (i_q == total_q) ? S_OUT : S_REB_KEY;
				end
				S_REB_KEY: begin
					state_q <= S_HASH;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// probe walk and result bookkeeping
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q        <= address;
				payload_q    <= '{kind: object_kind, count: element_count,
					stride: element_stride, flags: record_flags};
				res_status_q <= ST_IGNORED;
				res_slot_q   <= '0;
			end
			S_HASH: begin
				pos_q   <= hash_pos;
				n_q     <= '0;
				empty_q <= 1'b0;
				match_q <= 1'b0;
			end
			S_IDX: begin
				entry_q <= idx_rdata;
				empty_q <= idx_rdata == '0;
			end
			S_REC: begin
				match_q <= rec_rkey == key_q;
				n_q     <= n_q + NW'(1);
				// stay on the matching entry, else step with wrap
				if (rec_rkey != key_q) begin
					pos_q <= (pos_q == PW'(INDEX_CAPACITY - 1)) ? '0 : pos_q + PW'(1);
				end
			end
			S_FINISH: begin
				if (rebuild_q) begin
					if (!empty_q && !conflict_q) begin
						res_slot_q <= i_q[RW-1:0];
					end
				end else if (match_q) begin
					res_status_q <= ST_UPDATED;
					res_slot_q   <= hit_slot;
				end else if (empty_q && total_q < TW'(RECORD_CAPACITY)) begin
					res_status_q <= ST_INSERTED;
					res_slot_q   <= total_q[RW-1:0];
				end else begin
					res_status_q <= ST_FULL;
					res_slot_q   <= '0;
				end
			end
			S_REB_RD: begin
				if (i_q == total_q) begin
					res_status_q <= conflict_q ? ST_DUPLICATE : ST_REBUILT;
					if (!conflict_q) begin
						res_slot_q <= '0;
					end
				end
			end
			S_REB_KEY: begin
				key_q <= rec_rkey;
			end
			default: begin
			end
		endcase
	end

	// output register, loaded once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			status_q <= res_status_q;
			slot_q   <= SLOT_W'(res_slot_q);
			held_q   <= HELD_W'(total_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign record_slot  = slot_q;
	assign records_held = held_q;

	`HOR_ASSERT_NEXT(a_busy_after_take, in_take, state_q != S_IDLE,
		"block still idle after taking a transaction")
	`HOR_ASSERT_NOW(a_total_bound, 1'b1, total_q <= TW'(RECORD_CAPACITY),
		"record total above capacity")
	`HOR_ASSERT_NOW(a_out_from_result, $rose(out_valid_q), $past(state_q == S_OUT),
		"result presented without a finished transaction")
	`HOR_ASSERT_NOW(a_no_take_in_sweep, state_q == S_CLEAR, in_stall,
		"transaction taken during index sweep")
endmodule

>>> sim/tb.sv
// testbench for the hashed object registry: directed and random transactions checked by a predictor
`timescale 1ns / 1ps
module tb;
	import hor_pkg::*;

	localparam int RECORDS = 1024;
	localparam int SLOTS   = 2048;

	// one expected output transaction
	typedef struct {
		status_t            st;
		logic [SLOT_W-1:0]  slot;
		logic [HELD_W-1:0]  held;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                operation = 1'b0;
	logic [ADDR_W-1:0]   address = '0;
	logic [KIND_W-1:0]   object_kind = '0;
	logic [WORD_W-1:0]   element_count = '0;
	logic [WORD_W-1:0]   element_stride = '0;
	logic [WORD_W-1:0]   record_flags = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   record_slot;
	logic [HELD_W-1:0]   records_held;

	hashed_object_registry_top #(
		.RECORD_CAPACITY(RECORDS),
		.INDEX_CAPACITY (SLOTS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.address       (address),
		.object_kind   (object_kind),
		.element_count (element_count),
		.element_stride(element_stride),
		.record_flags  (record_flags),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.record_slot   (record_slot),
		.records_held  (records_held)
	);

	always #4 clk = ~clk;

	// shadow copy of the registry state
	logic [HELD_W-1:0] shadow_index [SLOTS];
	logic [ADDR_W-1:0] shadow_addr [RECORDS];
	int                shadow_total;

	outcome_t pending_outcomes[$];
	int       failures = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_request = 0;
	logic     in_taken = 1'b0;

	// handshake capture, taken before the block updates at this edge
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall && arst_n;
	end

	// first index position of a key
	function automatic int hash_position(logic [ADDR_W-1:0] key);
		logic [63:0] h;
		h = {16'b0, key} >> MIX_PRE_SHIFT;
		h ^= h >> MIX_XOR_SHIFT1;
		h = h * 64'hED5AD4BB;
		h ^= h >> MIX_XOR_SHIFT2;
		return int'(h[31:0] % SLOTS);
	endfunction

	// position holding the key or empty, -1 when the index is exhausted
	function automatic int find_position(logic [ADDR_W-1:0] key);
		int pos;
		int e;
		pos = hash_position(key);
		for (int n = 0; n < SLOTS; n++) begin
			e = int'(shadow_index[pos]);
			if (e == 0)
				return pos;
			if (e <= shadow_total && shadow_addr[e-1] == key)
				return pos;
			pos = (pos + 1) % SLOTS;
		end
		return -1;
	endfunction

	// apply one transaction to the shadow state and give its outcome
	function automatic outcome_t registry_outcome(logic op, logic [ADDR_W-1:0] key,
		logic [WORD_W-1:0] cnt);
		outcome_t o;
		int p;
		bit clash;
		o.slot = '0;
		clash = 1'b0;
		if (op) begin
			foreach (shadow_index[i]) shadow_index[i] = '0;
			o.st = ST_REBUILT;
			for (int i = 0; i < shadow_total; i++) begin
				p = find_position(shadow_addr[i]);
				if (p < 0 || shadow_index[p] != 0) begin
					if (!clash) begin
						clash = 1'b1;
						o.slot = SLOT_W'(i);
					end
				end else begin
					shadow_index[p] = HELD_W'(i + 1);
				end
			end
			if (clash)
				o.st = ST_DUPLICATE;
		end else if (key == 0 || cnt == 0) begin
			o.st = ST_IGNORED;
		end else begin
			p = find_position(key);
			if (p < 0) begin
				o.st = ST_FULL;
			end else if (shadow_index[p] != 0) begin
				o.st = ST_UPDATED;
				o.slot = SLOT_W'(shadow_index[p] - 1);
			end else if (shadow_total >= RECORDS) begin
				o.st = ST_FULL;
			end else begin
				shadow_addr[shadow_total] = key;
				shadow_index[p] = HELD_W'(shadow_total + 1);
				o.st = ST_INSERTED;
				o.slot = SLOT_W'(shadow_total);
				shadow_total++;
			end
		end
		o.held = HELD_W'(shadow_total);
		return o;
	endfunction

	// offer one transaction, predict its outcome once it is taken
	task automatic send_request(logic op, logic [ADDR_W-1:0] key, logic [KIND_W-1:0] kind,
		logic [WORD_W-1:0] cnt, logic [WORD_W-1:0] strd, logic [WORD_W-1:0] flg);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		address        <= key;
		object_kind    <= kind;
		element_count  <= cnt;
		element_stride <= strd;
		record_flags   <= flg;
		do
			@(negedge clk);
		while (!in_taken);
		pending_outcomes.push_back(registry_outcome(op, key, cnt));
	endtask

	task automatic send_register(logic [ADDR_W-1:0] key, logic [WORD_W-1:0] cnt);
		send_request(1'b0, key, KIND_W'($urandom), cnt, $urandom, $urandom);
	endtask

	task automatic send_rebuild();
		send_request(1'b1, ADDR_W'({$urandom, $urandom}), KIND_W'($urandom), $urandom,
			$urandom, $urandom);
	endtask

	// lower valid and wait until every outcome has been seen
	task automatic drain_outcomes();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] known_address();
		return shadow_addr[$urandom_range(shadow_total - 1)];
	endfunction

	// receiver: random stalls, or a long counted hold-off on request
	always @(negedge clk) begin
		int hold_left;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// output checker: compare each taken result with the oldest prediction
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result status %0d slot %0d held %0d",
					$time, status, record_slot, records_held);
				failures++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					failures++;
				end
				if (record_slot !== want.slot) begin
					$display("%0t: record_slot expected %0d actual %0d", $time, want.slot,
						record_slot);
					failures++;
				end
				if (records_held !== want.held) begin
					$display("%0t: records_held expected %0d actual %0d", $time, want.held,
						records_held);
					failures++;
				end
			end
		end
	end

	// field extremes, the ignored, inserted, updated and rebuilt codes, probe collisions and a small rebuild
	task automatic test_directed();
		logic [ADDR_W-1:0] base;
		base = 48'h1234_5678_9AB0;
		send_request(1'b0, '0, 4'hF, 32'hFFFF_FFFF, '1, '1);
		send_request(1'b0, 48'hFFFF_FFFF_FFFF, 4'h0, '0, '0, '0);
		send_request(1'b1, '0, '0, '0, '0, '0);
		send_request(1'b0, 48'h1, 4'h0, 32'h1, '0, '0);
		send_request(1'b0, 48'hFFFF_FFFF_FFFF, 4'hF, 32'hFFFF_FFFF, '1, '1);
		send_request(1'b0, 48'h1, 4'hA, 32'h5, 32'h10, 32'h8000_0001);
		// keys sharing the bits above the low nibble hash to one position
		for (int i = 0; i < 6; i++)
			send_register(base | ADDR_W'(i), $urandom_range(32'hFFFF_FFFF, 1));
		send_register(base | 48'h3, 32'h7);
		send_request(1'b0, 48'h8000_0000_0000, 4'h5, 32'h8000_0000, 32'h5555_5555,
			32'hAAAA_AAAA);
		send_request(1'b1, '1, 4'hF, '1, '1, '1);
		send_register(base | 48'h5, 32'h2);
		send_register(base | 48'h9, 32'h3);
		send_request(1'b0, base, 4'h0, '0, '0, '0);
		send_rebuild();
	endtask

	// well-formed traffic: mostly new keys, some updates, colliding keys, noise, rare rebuilds
	task automatic test_random(int items);
		int pick;
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(999);
			if (pick < 8)
				send_rebuild();
			else if (pick < 40)
				send_request(1'b0, $urandom_range(1) ? 48'h0 : ADDR_W'({$urandom, $urandom}),
					KIND_W'($urandom), $urandom_range(1) ? 32'h0 : $urandom, $urandom,
					$urandom);
			else if (pick < 140 && shadow_total > 0)
				send_register(known_address(), $urandom_range(32'hFFFF_FFFF, 1));
			else if (pick < 240 && shadow_total > 0)
				send_register(known_address() ^ ADDR_W'($urandom_range(15, 1)),
					$urandom_range(32'hFFFF_FFFF, 1));
			else
				send_register(ADDR_W'({$urandom, $urandom}) | 48'h1, $urandom);
		end
	endtask

	// receiver holds off long enough that the block stalls its input
	task automatic test_backpressure();
		hold_request = 400;
		for (int n = 0; n < 12; n++)
			send_register(ADDR_W'({$urandom, $urandom}) | 48'h10,
				$urandom_range(32'hFFFF_FFFF, 1));
		drain_outcomes();
	endtask

	// fill the store, then full requests, an update, a rebuild at capacity, an update and a full request
	task automatic test_store_full();
		while (shadow_total < RECORDS)
			send_register(ADDR_W'({$urandom, $urandom}) | 48'h1,
				$urandom_range(32'hFFFF_FFFF, 1));
		for (int n = 0; n < 6; n++)
			send_register(ADDR_W'({$urandom, $urandom}) | 48'h1,
				$urandom_range(32'hFFFF_FFFF, 1));
		send_register(known_address(), 32'h1);
		send_rebuild();
		send_register(known_address(), 32'hFFFF_FFFF);
		send_register(ADDR_W'({$urandom, $urandom}) | 48'h1, 32'h1);
		drain_outcomes();
	endtask

	initial begin
		foreach (shadow_index[i]) shadow_index[i] = '0;
		shadow_total = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 11;
		recv_stall_pct = 69;
		test_directed();
		drain_outcomes();
		test_random(370);
		test_backpressure();

		send_idle_pct = 69;
		recv_stall_pct = 11;
		test_random(370);
		drain_outcomes();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(380);
		test_store_full();

		repeat (100) @(negedge clk);
		if (failures == 0 && pending_outcomes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog for a hung block
	initial begin
		#16_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule

>>> hashed_object_registry_top.f
+incdir+rtl/core
rtl/core/hor_pkg.sv
rtl/core/hor_hash.sv
rtl/core/hor_index_mem.sv
rtl/core/hor_record_mem.sv
rtl/core/hashed_object_registry_top.sv
sim/tb.sv
